/* hw/rtl/sfdb_pkg.sv */
`timescale 1ns / 1ps

package sfdb_pkg;

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        CFG_COMPONENT_COUNT = 3'd0,
        CFG_DIVIDEND_VARIES = 3'd1,
        CFG_DIVISOR_VARIES  = 3'd2,
        CFG_UNI_DIVIDEND_X  = 3'd3,
        CFG_UNI_DIVIDEND_Y  = 3'd4,
        CFG_UNI_DIVIDEND_Z  = 3'd5,
        CFG_UNI_DIVIDEND_W  = 3'd6,
        CFG_UNI_DIVISOR     = 3'd7
    } t_cfg_idx;

    localparam logic [31:0] EXP_MASK    = 32'h7F80_0000;
    localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
    localparam logic [31:0] DEFAULT_NAN = 32'h7FC0_0000;
    localparam logic [31:0] FLOAT_ONE   = 32'h3F80_0000;

    // 26 quotient bits after the leading one, two per pipeline stage
    localparam int DIV_STEPS     = 26;
    localparam int STEPS_PER_STG = 2;
    localparam int DIV_STG       = DIV_STEPS / STEPS_PER_STG;

    // one lane while the quotient is being developed
    typedef struct packed {
        logic               special;
        logic [31:0]        spec_val;
        logic               sign;
        logic signed [10:0] expo;
        logic [23:0]        rem;
        logic [23:0]        dsr;
        logic [26:0]        quo;
    } t_lane;

    // one lane ahead of rounding
    typedef struct packed {
        logic        special;
        logic [31:0] spec_val;
        logic        sign;
        logic        ovf;
        logic [7:0]  expo;
        logic [26:0] sig;
    } t_rnd;

endpackage

/* hw/rtl/sfdb_prep.sv */
`timescale 1ns / 1ps

// classify, special results, normalize subnormals, first quotient bit
module sfdb_prep (
    input  logic [31:0]          i_a,
    input  logic [31:0]          i_b,
    output sfdb_pkg::t_lane      o_lane
);

    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        n = 5'd24;
        for (int i = 0; i < 24; i++) begin
            if (v[i]) begin
                n = 5'(23 - i);
            end
        end
        return n;
    endfunction

    always_comb begin
        logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
        logic [4:0]         a_lz, b_lz;
        logic [23:0]        ma, mb;
        logic signed [10:0] ea, eb;
        logic [24:0]        x;

        sgn    = i_a[31] ^ i_b[31];
        a_nan  = (i_a[30:23] == 8'hFF) && (i_a[22:0] != 23'd0);
        b_nan  = (i_b[30:23] == 8'hFF) && (i_b[22:0] != 23'd0);
        a_inf  = (i_a[30:23] == 8'hFF) && (i_a[22:0] == 23'd0);
        b_inf  = (i_b[30:23] == 8'hFF) && (i_b[22:0] == 23'd0);
        a_zero = i_a[30:0] == 31'd0;
        b_zero = i_b[30:0] == 31'd0;

        a_lz = lzc24({1'b0, i_a[22:0]});
        b_lz = lzc24({1'b0, i_b[22:0]});
        if (i_a[30:23] == 8'd0) begin
            ma = {1'b0, i_a[22:0]} << a_lz;
            ea = 11'sd1 - $signed({6'd0, a_lz});
        end else begin
            ma = {1'b1, i_a[22:0]};
            ea = $signed({3'd0, i_a[30:23]});
        end
        if (i_b[30:23] == 8'd0) begin
            mb = {1'b0, i_b[22:0]} << b_lz;
            eb = 11'sd1 - $signed({6'd0, b_lz});
        end else begin
            mb = {1'b1, i_b[22:0]};
            eb = $signed({3'd0, i_b[30:23]});
        end

        o_lane.sign = sgn;
        o_lane.dsr  = mb;
        o_lane.quo  = 27'd1;
        if (ma < mb) begin
            x           = {ma, 1'b0};
            o_lane.expo = ea - eb + 11'sd126;
        end else begin
            x           = {1'b0, ma};
            o_lane.expo = ea - eb + 11'sd127;
        end
        o_lane.rem = 24'(x - {1'b0, mb});

        o_lane.special  = 1'b1;
        if (a_nan) begin
            o_lane.spec_val = i_a | sfdb_pkg::QUIET_BIT;
        end else if (b_nan) begin
            o_lane.spec_val = i_b | sfdb_pkg::QUIET_BIT;
        end else if (a_inf) begin
            o_lane.spec_val = b_inf ? sfdb_pkg::DEFAULT_NAN : {sgn, sfdb_pkg::EXP_MASK[30:0]};
        end else if (b_inf) begin
            o_lane.spec_val = {sgn, 31'd0};
        end else if (b_zero) begin
            o_lane.spec_val = a_zero ? sfdb_pkg::DEFAULT_NAN : {sgn, sfdb_pkg::EXP_MASK[30:0]};
        end else if (a_zero) begin
            o_lane.spec_val = {sgn, 31'd0};
        end else begin
            o_lane.special  = 1'b0;
            o_lane.spec_val = 32'd0;
        end
    end

endmodule

/* hw/rtl/sfdb_div_stage.sv */
`timescale 1ns / 1ps

// restoring division, STEPS_PER_STG quotient bits
module sfdb_div_stage (
    input  sfdb_pkg::t_lane i_lane,
    output sfdb_pkg::t_lane o_lane
);

    always_comb begin
        logic [24:0] r2;
        o_lane = i_lane;
        for (int i = 0; i < sfdb_pkg::STEPS_PER_STG; i++) begin
            r2 = {o_lane.rem, 1'b0};
            if (r2 >= {1'b0, o_lane.dsr}) begin
                o_lane.rem = 24'(r2 - {1'b0, o_lane.dsr});
                o_lane.quo = {o_lane.quo[25:0], 1'b1};
            end else begin
                o_lane.rem = r2[23:0];
                o_lane.quo = {o_lane.quo[25:0], 1'b0};
            end
        end
    end

endmodule

/* hw/rtl/sfdb_denorm.sv */
`timescale 1ns / 1ps

// sticky fold, overflow detect, right shift into the subnormal range
module sfdb_denorm (
    input  sfdb_pkg::t_lane i_lane,
    output sfdb_pkg::t_rnd  o_rnd
);

    always_comb begin
        logic [26:0] q;
        logic [10:0] s_full;
        logic [4:0]  s;
        logic        lost;

        q      = i_lane.quo | {26'd0, (i_lane.rem != 24'd0)};
        s_full = 11'(11'sd1 - i_lane.expo);
        s      = s_full[4:0];
        lost   = 1'b0;

        o_rnd.special  = i_lane.special;
        o_rnd.spec_val = i_lane.spec_val;
        o_rnd.sign     = i_lane.sign;
        o_rnd.ovf      = i_lane.expo >= 11'sd255;
        o_rnd.expo     = i_lane.expo[7:0];
        if (i_lane.expo < 11'sd1) begin
            if (s_full >= 11'd27) begin
                q = 27'd1;
            end else begin
                lost = |(q & ~({27{1'b1}} << s));
                q    = (q >> s) | {26'd0, lost};
            end
            o_rnd.expo = 8'd1;
        end
        o_rnd.sig = q;
    end

endmodule

/* hw/rtl/sfdb_round.sv */
`timescale 1ns / 1ps

// round to nearest even and pack
module sfdb_round (
    input  sfdb_pkg::t_rnd i_rnd,
    output logic [31:0]    o_res
);

    always_comb begin
        logic [2:0]  g;
        logic [23:0] m;
        logic        inc;
        logic [31:0] res;

        g   = i_rnd.sig[2:0];
        m   = i_rnd.sig[26:3];
        inc = (g > 3'd4) || ((g == 3'd4) && m[0]);
        res = {1'b0, 8'(i_rnd.expo - 8'd1), 23'd0} + {7'd0, 25'({1'b0, m} + {24'd0, inc})};
        if (res >= sfdb_pkg::EXP_MASK) begin
            res = sfdb_pkg::EXP_MASK;
        end
        if (i_rnd.special) begin
            o_res = i_rnd.spec_val;
        end else if (i_rnd.ovf) begin
            o_res = {i_rnd.sign, sfdb_pkg::EXP_MASK[30:0]};
        end else begin
            o_res = {i_rnd.sign, res[30:0]};
        end
    end

endmodule

/* hw/rtl/simd_float_divide_broadcast.sv */
`timescale 1ns / 1ps

// Four-lane IEEE-754 single divide, one shading element per item.
// Input channel: i_valid / o_stall with dividend x..w, divisor, last flag.
// Output channel: o_valid / i_stall with quotient x..w and the last flag.
// Config: i_cfg_we writes i_cfg_data into register i_cfg_idx; write only
// while the pipe is empty. Component count 0 acts as 1, above
// MAX_COMPONENTS as MAX_COMPONENTS; inactive components give zero.
// Pipeline: 17 register stages (input register, unpack, 13 divide stages
// at two quotient bits each, subnormal shift, round).
// Throughput: one item per cycle while no stall holds the pipe; the depth
// is set by the 26-step restoring divide.
// Stall: each stage moves when the next one is empty or moving, so
// bubbles close up and o_stall rises only once every stage holds an item.
// Reset: pipe emptied, registers return to count 1, both operands
// varying, uniform dividend 0, uniform divisor 1.0.
module simd_float_divide_broadcast #(
    parameter int MAX_COMPONENTS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_dividend_x,
    input  logic [31:0] i_dividend_y,
    input  logic [31:0] i_dividend_z,
    input  logic [31:0] i_dividend_w,
    input  logic [31:0] i_divisor_in,
    input  logic        i_last_element,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_quotient_x,
    output logic [31:0] o_quotient_y,
    output logic [31:0] o_quotient_z,
    output logic [31:0] o_quotient_w,
    output logic        o_last_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam int NL   = MAX_COMPONENTS;
    localparam int DSTG = sfdb_pkg::DIV_STG;
    localparam int NSTG = DSTG + 4;   // in, unpack, divide, denorm, out

    // configuration registers
    logic [2:0]  r_cnt;
    logic        r_dvd_var;
    logic        r_dsr_var;
    logic [31:0] r_uni [4];
    logic [31:0] r_uni_dsr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= 3'd1;
            r_dvd_var <= 1'b1;
            r_dsr_var <= 1'b1;
            for (int k = 0; k < 4; k++) begin
                r_uni[k] <= 32'd0;
            end
            r_uni_dsr <= sfdb_pkg::FLOAT_ONE;
        end else if (i_cfg_we) begin
            unique case (sfdb_pkg::t_cfg_idx'(i_cfg_idx))
                sfdb_pkg::CFG_COMPONENT_COUNT: r_cnt     <= i_cfg_data[2:0];
                sfdb_pkg::CFG_DIVIDEND_VARIES: r_dvd_var <= i_cfg_data[0];
                sfdb_pkg::CFG_DIVISOR_VARIES:  r_dsr_var <= i_cfg_data[0];
                sfdb_pkg::CFG_UNI_DIVIDEND_X:  r_uni[0]  <= i_cfg_data;
                sfdb_pkg::CFG_UNI_DIVIDEND_Y:  r_uni[1]  <= i_cfg_data;
                sfdb_pkg::CFG_UNI_DIVIDEND_Z:  r_uni[2]  <= i_cfg_data;
                sfdb_pkg::CFG_UNI_DIVIDEND_W:  r_uni[3]  <= i_cfg_data;
                sfdb_pkg::CFG_UNI_DIVISOR:     r_uni_dsr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // active lane mask from the clamped count
    logic [2:0]    w_cnt;
    logic [NL-1:0] w_act;
    logic [31:0]   w_in [4];

    assign w_in[0] = i_dividend_x;
    assign w_in[1] = i_dividend_y;
    assign w_in[2] = i_dividend_z;
    assign w_in[3] = i_dividend_w;

    always_comb begin
        if (r_cnt == 3'd0) begin
            w_cnt = 3'd1;
        end else if (r_cnt > 3'(NL)) begin
            w_cnt = 3'(NL);
        end else begin
            w_cnt = r_cnt;
        end
        for (int l = 0; l < NL; l++) begin
            w_act[l] = 3'(l) < w_cnt;
        end
    end

    // handshake: a stage loads when it is empty or its successor moves
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_rdy;
    logic [NSTG-1:0] r_last;
    logic [NL-1:0]   r_act [NSTG];

    always_comb begin
        w_rdy[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign o_stall = !w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_last[0] <= i_last_element;
            r_act[0]  <= w_act;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (w_rdy[k]) begin
                r_last[k] <= r_last[k-1];
                r_act[k]  <= r_act[k-1];
            end
        end
    end

    // datapath
    logic [31:0]     r_a [NL];
    logic [31:0]     r_b;
    sfdb_pkg::t_lane w_prep [NL];
    sfdb_pkg::t_lane r_ln   [DSTG+1][NL];
    sfdb_pkg::t_lane w_div  [DSTG][NL];
    sfdb_pkg::t_rnd  w_den  [NL];
    sfdb_pkg::t_rnd  r_den  [NL];
    logic [31:0]     w_res  [NL];
    logic [31:0]     r_q    [NL];

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_b <= r_dsr_var ? i_divisor_in : r_uni_dsr;
            for (int l = 0; l < NL; l++) begin
                r_a[l] <= r_dvd_var ? w_in[l] : r_uni[l];
            end
        end
    end

    genvar l, j;
    generate
        for (l = 0; l < NL; l++) begin : g_lane
            sfdb_prep u_prep (
                .i_a    (r_a[l]),
                .i_b    (r_b),
                .o_lane (w_prep[l])
            );

            always_ff @(posedge i_clk) begin
                if (w_rdy[1]) begin
                    r_ln[0][l] <= w_prep[l];
                end
            end

            for (j = 0; j < DSTG; j++) begin : g_div
                sfdb_div_stage u_div (
                    .i_lane (r_ln[j][l]),
                    .o_lane (w_div[j][l])
                );

                always_ff @(posedge i_clk) begin
                    if (w_rdy[j+2]) begin
                        r_ln[j+1][l] <= w_div[j][l];
                    end
                end
            end

            sfdb_denorm u_den (
                .i_lane (r_ln[DSTG][l]),
                .o_rnd  (w_den[l])
            );

            always_ff @(posedge i_clk) begin
                if (w_rdy[NSTG-2]) begin
                    r_den[l] <= w_den[l];
                end
            end

            sfdb_round u_rnd (
                .i_rnd (r_den[l]),
                .o_res (w_res[l])
            );

            always_ff @(posedge i_clk) begin
                if (w_rdy[NSTG-1]) begin
                    r_q[l] <= r_act[NSTG-2][l] ? w_res[l] : 32'd0;
                end
            end
        end
    endgenerate

    // lanes beyond MAX_COMPONENTS read as zero
    logic [31:0] w_qo [4];
    genvar m;
    generate
        for (m = 0; m < 4; m++) begin : g_out
            if (m < NL) begin : g_on
                assign w_qo[m] = r_q[m];
            end else begin : g_off
                assign w_qo[m] = 32'd0;
            end
        end
    endgenerate

    assign o_valid      = r_vld[NSTG-1];
    assign o_last_out   = r_last[NSTG-1];
    assign o_quotient_x = w_qo[0];
    assign o_quotient_y = w_qo[1];
    assign o_quotient_z = w_qo[2];
    assign o_quotient_w = w_qo[3];

    // back-pressure only once every stage is full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("input stalled with a bubble in the pipe");

    // a stalled result is never dropped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("stalled result lost");

    // lane x is always active
    a_lane0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_act[NSTG-1][0])
        else $error("lane x inactive");

endmodule

/* tb/sv/sfdb_checker.sv */
`timescale 1ns / 1ps

module sfdb_checker
    import sfdb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic [31:0] i_dividend_x,
    input  logic [31:0] i_dividend_y,
    input  logic [31:0] i_dividend_z,
    input  logic [31:0] i_dividend_w,
    input  logic [31:0] i_divisor_in,
    input  logic        i_last_element,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_quotient_x,
    input  logic [31:0] i_quotient_y,
    input  logic [31:0] i_quotient_z,
    input  logic [31:0] i_quotient_w,
    input  logic        i_last_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_cnt,
    output int          o_pending
);

    typedef struct packed {
        logic [3:0][31:0] quo;
        logic             last;
    } t_quo_item;

    t_quo_item   quo_q[$];
    logic [2:0]  comp_cnt;
    logic        dvd_vary;
    logic        dsr_vary;
    logic [3:0][31:0] uni_dvd;
    logic [31:0] uni_dsr;

    // unpack finite nonzero operand to 24-bit significand
    function automatic void norm_op(input logic [31:0] v, output int ex,
                                    output logic [23:0] m);
        ex = int'(v[30:23]);
        m  = {1'b0, v[22:0]};
        if (ex == 0) begin
            ex = 1;
            while (!m[23]) begin
                m = m << 1;
                ex--;
            end
        end else begin
            m[23] = 1'b1;
        end
    endfunction

    function automatic logic [31:0] ieee_div(input logic [31:0] a, input logic [31:0] b);
        logic        sgn;
        int          ea, eb, e, s;
        logic [23:0] ma, mb;
        logic [63:0] num;
        logic [31:0] q, res;
        logic [2:0]  rnd;
        sgn = a[31] ^ b[31];
        if (a[30:23] == 8'hFF && a[22:0] != 0) return a | QUIET_BIT;
        if (b[30:23] == 8'hFF && b[22:0] != 0) return b | QUIET_BIT;
        if (a[30:0] == EXP_MASK[30:0])
            return (b[30:0] == EXP_MASK[30:0]) ? DEFAULT_NAN : {sgn, EXP_MASK[30:0]};
        if (b[30:0] == EXP_MASK[30:0]) return {sgn, 31'd0};
        if (b[30:0] == 0) return (a[30:0] == 0) ? DEFAULT_NAN : {sgn, EXP_MASK[30:0]};
        if (a[30:0] == 0) return {sgn, 31'd0};
        norm_op(a, ea, ma);
        norm_op(b, eb, mb);
        e = ea - eb + 127;
        if (ma < mb) begin
            num = {40'd0, ma} << 27;
            e -= 1;
        end else begin
            num = {40'd0, ma} << 26;
        end
        q = 32'(num / mb);
        if (num % mb != 0) q[0] = 1'b1;
        if (e >= 255) return {sgn, EXP_MASK[30:0]};
        if (e < 1) begin
            s = 1 - e;
            if (s >= 27) q = 1;
            else q = (q >> s) | ((q & ((32'd1 << s) - 1)) != 0);
            e = 1;
        end
        rnd = q[2:0];
        q = q >> 3;
        if (rnd > 4 || (rnd == 4 && q[0])) q++;
        res = (32'(e - 1) << 23) + q;
        if (res >= EXP_MASK) res = EXP_MASK;
        return {sgn, res[30:0]};
    endfunction

    function automatic t_quo_item predict_quo(input logic [3:0][31:0] dvd_in,
                                              input logic [31:0] dsr_in, input logic lst);
        t_quo_item   r;
        int          n;
        logic [31:0] dsr;
        n = (comp_cnt == 0) ? 1 : (comp_cnt > 4) ? 4 : int'(comp_cnt);
        dsr = dsr_vary ? dsr_in : uni_dsr;
        for (int k = 0; k < 4; k++)
            r.quo[k] = (k < n) ? ieee_div(dvd_vary ? dvd_in[k] : uni_dvd[k], dsr) : 32'd0;
        r.last = lst;
        return r;
    endfunction

    function automatic void cmp_field(input string nm, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %h actual %h", nm, exp_v, act_v);
            o_fail_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_quo_item e;
        if (!i_rst_n) begin
            comp_cnt <= 3'd1;
            dvd_vary <= 1'b1;
            dsr_vary <= 1'b1;
            uni_dvd  <= '0;
            uni_dsr  <= FLOAT_ONE;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_COMPONENT_COUNT: comp_cnt   <= i_cfg_data[2:0];
                    CFG_DIVIDEND_VARIES: dvd_vary   <= i_cfg_data[0];
                    CFG_DIVISOR_VARIES:  dsr_vary   <= i_cfg_data[0];
                    CFG_UNI_DIVIDEND_X:  uni_dvd[0] <= i_cfg_data;
                    CFG_UNI_DIVIDEND_Y:  uni_dvd[1] <= i_cfg_data;
                    CFG_UNI_DIVIDEND_Z:  uni_dvd[2] <= i_cfg_data;
                    CFG_UNI_DIVIDEND_W:  uni_dvd[3] <= i_cfg_data;
                    CFG_UNI_DIVISOR:     uni_dsr    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !i_in_stall)
                quo_q.push_back(predict_quo({i_dividend_w, i_dividend_z, i_dividend_y,
                                             i_dividend_x}, i_divisor_in, i_last_element));
            if (i_out_valid && !i_out_stall) begin
                if (quo_q.size() == 0) begin
                    $error("unexpected item at output");
                    o_fail_cnt++;
                end else begin
                    e = quo_q.pop_front();
                    cmp_field("quotient_x", e.quo[0], i_quotient_x);
                    cmp_field("quotient_y", e.quo[1], i_quotient_y);
                    cmp_field("quotient_z", e.quo[2], i_quotient_z);
                    cmp_field("quotient_w", e.quo[3], i_quotient_w);
                    cmp_field("last_out", 32'(e.last), 32'(i_last_out));
                end
            end
        end
        o_pending = quo_q.size();
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import sfdb_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid, in_stall;
    logic [31:0] dvd_x, dvd_y, dvd_z, dvd_w, dsr;
    logic        lst;
    logic        out_valid, out_stall;
    logic [31:0] quo_x, quo_y, quo_z, quo_w;
    logic        last_out;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [31:0] cfg_data;
    int          fail_cnt, pending;

    // receiver behavior: 0 random bursts, 1 one long hold-off then random bursts, 2 never stall
    int          rx_mode;

    simd_float_divide_broadcast u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_dividend_x(dvd_x), .i_dividend_y(dvd_y), .i_dividend_z(dvd_z),
        .i_dividend_w(dvd_w), .i_divisor_in(dsr), .i_last_element(lst),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_quotient_x(quo_x), .o_quotient_y(quo_y), .o_quotient_z(quo_z),
        .o_quotient_w(quo_w), .o_last_out(last_out),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    sfdb_checker u_chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_in_stall(in_stall),
        .i_dividend_x(dvd_x), .i_dividend_y(dvd_y), .i_dividend_z(dvd_z),
        .i_dividend_w(dvd_w), .i_divisor_in(dsr), .i_last_element(lst),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_quotient_x(quo_x), .i_quotient_y(quo_y), .i_quotient_z(quo_z),
        .i_quotient_w(quo_w), .i_last_out(last_out),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_cnt(fail_cnt), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // operands biased toward the interesting corners of binary32
    function automatic logic [31:0] pick_float();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 11))
            0: v[30:23] = 8'hFF;                       // inf or NaN
            1: v[30:0]  = 31'd0;                       // zero
            2: v[30:23] = 8'h00;                       // subnormal
            3: v[30:23] = 8'(int'($urandom_range(0, 20)));
            4: v[30:23] = 8'(int'($urandom_range(230, 254)));
            5: v[22:0]  = ($urandom_range(0, 1)) ? 23'd0 : 23'h7FFFFF;
            6: v[30:0]  = {8'hFF, 23'd0};              // inf
            default: v[30:23] = 8'(int'($urandom_range(100, 154)));
        endcase
        return v;
    endfunction

    task automatic send_item(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic [31:0] w,
                             input logic [31:0] d, input logic l, input bit gaps);
        int gap;
        // idle burst before offering, sender side
        if (gaps && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        dvd_x <= x; dvd_y <= y; dvd_z <= z; dvd_w <= w;
        dsr <= d; lst <= l;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // one write, then the config port goes idle before the task returns
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    // quiet the pipe before touching config: all results back, plus drain margin
    task automatic drain_pipe();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic rand_item(input bit gaps);
        send_item(pick_float(), pick_float(), pick_float(), pick_float(), pick_float(),
                  1'($urandom), gaps);
    endtask

    // receiver stall process
    initial begin
        int n;
        bit held;
        out_stall = 1'b0;
        held      = 1'b0;
        forever begin
            @(posedge clk);
            if (rx_mode == 1 && !held) begin
                // long hold-off so the pipe fills and o_stall rises
                out_stall <= 1'b1;
                repeat (200) @(posedge clk);
                out_stall <= 1'b0;
                held = 1'b1;
            end else if (rx_mode != 2 && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 19);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end else if (rx_mode != 2 && $urandom_range(0, 3) == 0) begin
                // a stretch with no stall at all
                repeat ($urandom_range(10, 40)) @(posedge clk);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int cnt;
        rx_mode  = 0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        dvd_x = '0; dvd_y = '0; dvd_z = '0; dvd_w = '0; dsr = '0; lst = 1'b0;
        cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners at reset config (count 1, all varying)
        send_item(32'h0000_0000, '0, '0, '0, 32'h0000_0000, 1'b0, 0); // 0/0
        send_item(32'h7F80_0000, '0, '0, '0, 32'hFF80_0000, 1'b1, 0); // inf/inf
        send_item(32'h3F80_0000, '0, '0, '0, 32'h8000_0000, 1'b0, 0); // x/0
        send_item(32'hBF80_0000, '0, '0, '0, 32'h7F80_0000, 1'b0, 0); // x/inf
        send_item(32'h7F80_0001, '0, '0, '0, 32'h7FC0_0000, 1'b0, 0); // NaN dividend
        send_item(32'h3F80_0000, '0, '0, '0, 32'hFF80_0001, 1'b1, 0); // NaN divisor
        send_item(32'h7F7F_FFFF, '0, '0, '0, 32'h0000_0001, 1'b0, 0); // overflow
        send_item(32'h0000_0001, '0, '0, '0, 32'h7F7F_FFFF, 1'b0, 0); // underflow
        send_item(32'h0080_0000, '0, '0, '0, 32'h4000_0000, 1'b0, 0); // to subnormal
        send_item(32'h0000_0003, '0, '0, '0, 32'h0000_0002, 1'b1, 0); // subnormal ops
        send_item(32'h4040_0000, '0, '0, '0, 32'h4040_0000, 1'b0, 0); // exact
        send_item(32'h3F80_0000, '0, '0, '0, 32'h4040_0000, 1'b0, 0); // 1/3 rounding
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 1'b1, 0);
        drain_pipe();

        // phases: count (incl. 0 and above max), operand sources, uniform values
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(CFG_COMPONENT_COUNT, (ph < 8) ? 32'(ph) : 32'($urandom_range(0, 7)));
            write_reg(CFG_DIVIDEND_VARIES, 32'(ph % 2 == 0 || ph == 9));
            write_reg(CFG_DIVISOR_VARIES, 32'(ph % 3 != 1 || ph == 9));
            write_reg(CFG_UNI_DIVIDEND_X, (ph == 1) ? 32'hFFFF_FFFF : pick_float());
            write_reg(CFG_UNI_DIVIDEND_Y, (ph == 1) ? 32'h0000_0000 : pick_float());
            write_reg(CFG_UNI_DIVIDEND_Z, pick_float());
            write_reg(CFG_UNI_DIVIDEND_W, pick_float());
            write_reg(CFG_UNI_DIVISOR, (ph == 4) ? 32'h0000_0000 : pick_float());
            cnt = (ph == 9) ? 300 : 160;
            if (ph == 3) rx_mode = 1;
            if (ph == 9) rx_mode = 2; // last part: no idling on either side
            for (int i = 0; i < cnt; i++) rand_item(ph != 9);
            drain_pipe();
        end

        if (fail_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
